### rtl/mpq_pkg.sv
// Package for the min priority queue: operation and status codes, controller
// states, and the command and status structs between controller and datapath.
// No dependencies.
package mpq_pkg;

    localparam logic signed [31:0] EMPTY_MARK = 32'sd99999;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_FIND    = 2'd1,
        OP_EXTRACT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_FIND_WAIT,
        S_EXT_WAIT,
        S_DN_CHK,
        S_DN_CMP,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_MARK,
        RES_ROOT
    } res_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_ZERO,
        IDX_PARENT,
        IDX_CHILD
    } idx_sel_t;

    typedef enum logic [1:0] {
        RD_PARENT,
        RD_ROOT_LAST,
        RD_CHILDREN
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_KEY,
        WR_PARENT,
        WR_CHILD
    } wr_sel_t;

    typedef enum logic {
        KEY_IN,
        KEY_LAST
    } key_sel_t;

    typedef struct packed {
        logic     key_ld;
        key_sel_t key_sel;
        idx_sel_t idx_sel;
        logic     cnt_inc;
        logic     cnt_dec;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     res_we;
        res_sel_t res_sel;
        status_t  res_status;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic idx_zero;
        logic parent_le_key;
        logic has_left;
        logic child_lt_key;
    } dp_status_t;

endpackage

### rtl/mpq_chan_if.sv
// Valid/ready channel interfaces for the min priority queue: the operation
// channel and the result channel. No dependencies.
interface mpq_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] key_in;

    modport source (output valid, output op, output key_in, input ready);
    modport sink   (input valid, input op, input key_in, output ready);
endinterface

interface mpq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] key_out;
    logic [1:0]         status;
    logic [6:0]         occupancy;

    modport source (output valid, output key_out, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input key_out, input status, input occupancy,
                    output ready);
endinterface

### rtl/mpq_dpath.sv
// Datapath of the min priority queue: heap memory, key count, hole index and
// key, and the result registers. Depends on mpq_pkg.
module mpq_dpath #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mpq_pkg::cmd_t       cmd,
    output mpq_pkg::dp_status_t sts,
    input  logic signed [31:0]  key_in,
    output logic signed [31:0]  key_out,
    output logic [1:0]          status,
    output logic [6:0]          occupancy
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    logic signed [31:0] mem [CAPACITY];

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      idx_next;
    logic signed [31:0] key_reg;
    logic signed [31:0] rd_a_reg;
    logic signed [31:0] rd_b_reg;
    logic signed [31:0] res_key_reg;
    mpq_pkg::status_t   res_status_reg;
    logic signed [31:0] out_key_reg;
    logic [1:0]         out_status_reg;
    logic [6:0]         out_occ_reg;

    logic [AW-1:0]      parent_idx;
    logic [IW-1:0]      left_idx;
    logic [IW-1:0]      right_idx;
    logic [IW-1:0]      count_wide;
    logic               has_right;
    logic               use_right;
    logic signed [31:0] child_val;
    logic [AW-1:0]      child_idx;
    logic [AW-1:0]      rd_a_addr;
    logic [AW-1:0]      rd_b_addr;
    logic signed [31:0] wr_data;

    assign parent_idx = (idx_reg - AW'(1)) >> 1;
    assign left_idx   = {1'b0, idx_reg, 1'b1};
    assign right_idx  = {1'b0, idx_reg, 1'b0} + IW'(2);
    assign count_wide = IW'(count_reg);
    assign has_right  = right_idx < count_wide;
    assign use_right  = has_right && (rd_b_reg < rd_a_reg);
    assign child_val  = use_right ? rd_b_reg : rd_a_reg;
    assign child_idx  = use_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

    assign sts.full          = count_reg == CW'(CAPACITY);
    assign sts.empty         = count_reg == '0;
    assign sts.idx_zero      = idx_reg == '0;
    assign sts.parent_le_key = rd_a_reg <= key_reg;
    assign sts.has_left      = left_idx < count_wide;
    assign sts.child_lt_key  = sts.has_left && (child_val < key_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            mpq_pkg::RD_PARENT:
            begin
                rd_a_addr = parent_idx;
                rd_b_addr = parent_idx;
            end
            mpq_pkg::RD_ROOT_LAST:
            begin
                rd_a_addr = '0;
                rd_b_addr = AW'(count_reg - CW'(1));
            end
            mpq_pkg::RD_CHILDREN:
            begin
                rd_a_addr = left_idx[AW-1:0];
                rd_b_addr = right_idx[AW-1:0];
            end
            default:
            begin
                rd_a_addr = '0;
                rd_b_addr = '0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            mpq_pkg::WR_KEY:    wr_data = key_reg;
            mpq_pkg::WR_PARENT: wr_data = rd_a_reg;
            mpq_pkg::WR_CHILD:  wr_data = child_val;
            default:            wr_data = key_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.idx_sel)
            mpq_pkg::IDX_COUNT:  idx_next = AW'(count_reg);
            mpq_pkg::IDX_ZERO:   idx_next = '0;
            mpq_pkg::IDX_PARENT: idx_next = parent_idx;
            mpq_pkg::IDX_CHILD:  idx_next = child_idx;
            default:             idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[idx_reg] <= wr_data;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.key_ld)
        begin
            key_reg <= (cmd.key_sel == mpq_pkg::KEY_LAST) ? rd_b_reg : key_in;
        end
        if (cmd.res_we)
        begin
            res_status_reg <= cmd.res_status;
            case (cmd.res_sel)
                mpq_pkg::RES_MARK: res_key_reg <= mpq_pkg::EMPTY_MARK;
                mpq_pkg::RES_ROOT: res_key_reg <= rd_a_reg;
                default:           res_key_reg <= '0;
            endcase
        end
        if (cmd.out_load)
        begin
            out_key_reg    <= res_key_reg;
            out_status_reg <= 2'(res_status_reg);
            out_occ_reg    <= 7'(count_reg);
        end
    end

    assign key_out   = out_key_reg;
    assign status    = out_status_reg;
    assign occupancy = out_occ_reg;

endmodule

### rtl/mpq_ctrl.sv
// Controller of the min priority queue: sequences insert sift-up, extract
// sift-down and find, and owns both handshakes. Depends on mpq_pkg.
module mpq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_op,
    output logic                out_valid,
    input  logic                out_ready,
    input  mpq_pkg::dp_status_t sts,
    output mpq_pkg::cmd_t       cmd
);

    mpq_pkg::state_t state_reg;
    mpq_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;
    mpq_pkg::op_t    op;

    assign op       = mpq_pkg::op_t'(in_op);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = state_reg == mpq_pkg::S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        mpq_pkg::OP_INSERT:
                            state_next = sts.full ? mpq_pkg::S_DONE : mpq_pkg::S_UP_CHK;
                        mpq_pkg::OP_FIND:
                            state_next = sts.empty ? mpq_pkg::S_DONE : mpq_pkg::S_FIND_WAIT;
                        mpq_pkg::OP_EXTRACT:
                            state_next = sts.empty ? mpq_pkg::S_DONE : mpq_pkg::S_EXT_WAIT;
                        default:
                            state_next = mpq_pkg::S_DONE;
                    endcase
                end
            end
            mpq_pkg::S_UP_CHK:
                state_next = sts.idx_zero ? mpq_pkg::S_DONE : mpq_pkg::S_UP_CMP;
            mpq_pkg::S_UP_CMP:
                state_next = sts.parent_le_key ? mpq_pkg::S_DONE : mpq_pkg::S_UP_CHK;
            mpq_pkg::S_FIND_WAIT:
                state_next = mpq_pkg::S_DONE;
            mpq_pkg::S_EXT_WAIT:
                state_next = mpq_pkg::S_DN_CHK;
            mpq_pkg::S_DN_CHK:
                state_next = (sts.empty || !sts.has_left) ? mpq_pkg::S_DONE
                                                          : mpq_pkg::S_DN_CMP;
            mpq_pkg::S_DN_CMP:
                state_next = sts.child_lt_key ? mpq_pkg::S_DN_CHK : mpq_pkg::S_DONE;
            mpq_pkg::S_DONE:
                state_next = out_free ? mpq_pkg::S_IDLE : mpq_pkg::S_DONE;
            default:
                state_next = mpq_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.key_sel    = mpq_pkg::KEY_IN;
        cmd.idx_sel    = mpq_pkg::IDX_HOLD;
        cmd.rd_sel     = mpq_pkg::RD_PARENT;
        cmd.wr_sel     = mpq_pkg::WR_KEY;
        cmd.res_sel    = mpq_pkg::RES_ZERO;
        cmd.res_status = mpq_pkg::ST_OK;
        case (state_reg)
            mpq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.res_we = 1'b1;
                    case (op)
                        mpq_pkg::OP_INSERT:
                        begin
                            if (sts.full)
                            begin
                                cmd.res_status = mpq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.key_ld  = 1'b1;
                                cmd.idx_sel = mpq_pkg::IDX_COUNT;
                                cmd.cnt_inc = 1'b1;
                            end
                        end
                        mpq_pkg::OP_FIND, mpq_pkg::OP_EXTRACT:
                        begin
                            cmd.rd_sel = mpq_pkg::RD_ROOT_LAST;
                            if (sts.empty)
                            begin
                                cmd.res_sel    = mpq_pkg::RES_MARK;
                                cmd.res_status = mpq_pkg::ST_EMPTY;
                            end
                        end
                        default:
                        begin
                            cmd.res_status = mpq_pkg::ST_OK;
                        end
                    endcase
                end
            end
            mpq_pkg::S_UP_CHK:
            begin
                cmd.rd_sel = mpq_pkg::RD_PARENT;
                if (sts.idx_zero)
                begin
                    cmd.wr_en = 1'b1;
                end
            end
            mpq_pkg::S_UP_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (!sts.parent_le_key)
                begin
                    cmd.wr_sel  = mpq_pkg::WR_PARENT;
                    cmd.idx_sel = mpq_pkg::IDX_PARENT;
                end
            end
            mpq_pkg::S_FIND_WAIT:
            begin
                cmd.res_we  = 1'b1;
                cmd.res_sel = mpq_pkg::RES_ROOT;
            end
            mpq_pkg::S_EXT_WAIT:
            begin
                cmd.res_we  = 1'b1;
                cmd.res_sel = mpq_pkg::RES_ROOT;
                cmd.key_ld  = 1'b1;
                cmd.key_sel = mpq_pkg::KEY_LAST;
                cmd.cnt_dec = 1'b1;
                cmd.idx_sel = mpq_pkg::IDX_ZERO;
            end
            mpq_pkg::S_DN_CHK:
            begin
                cmd.rd_sel = mpq_pkg::RD_CHILDREN;
                if (!sts.empty && !sts.has_left)
                begin
                    cmd.wr_en = 1'b1;
                end
            end
            mpq_pkg::S_DN_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (sts.child_lt_key)
                begin
                    cmd.wr_sel  = mpq_pkg::WR_CHILD;
                    cmd.idx_sel = mpq_pkg::IDX_CHILD;
                end
            end
            mpq_pkg::S_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/min_priority_queue_unit.sv
// Top level of the min priority queue: controller and datapath joined by
// command and status structs. Depends on mpq_pkg, mpq_chan_if, mpq_ctrl, mpq_dpath.
//
// Usage: each item on req carries an op (insert, find minimum, extract
// minimum) and a key; each item gives exactly one result on rsp with the key,
// a status (ok, empty, full) and the occupancy after the operation.
// Keys live in a binary min-heap in a single memory with one write port and
// two registered read ports. Items are processed one at a time; req is ready
// only while the controller is idle. Find reads the root and then registers it as
// the result; insert writes the new key at the end and sifts it up, each level a
// parent read (S_UP_CHK) then a compare and write (S_UP_CMP); extract reads the
// root and last key, moves the last key to the root and sifts it down, each level
// a child read (S_DN_CHK) then a compare and write (S_DN_CMP). The registered
// memory reads in the sift loops are why each level has a read state before its compare.
// Full inserts, empty finds and empty extracts go straight to the done state.
// A result waits in an output register while rsp is stalled; the next item is
// accepted meanwhile and held at its end until the register is free.
// Reset empties the queue at once; the memory needs no clearing.
module min_priority_queue_unit #(
    parameter int CAPACITY = 64
) (
    input logic      clk,
    input logic      rst_n,
    mpq_in_if.sink   req,
    mpq_out_if.source rsp
);

    mpq_pkg::cmd_t       cmd;
    mpq_pkg::dp_status_t sts;

    mpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_op     (req.op),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mpq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .key_in    (req.key_in),
        .key_out   (rsp.key_out),
        .status    (rsp.status),
        .occupancy (rsp.occupancy)
    );

endmodule

### bench/min_priority_queue_unit_tb.sv
// Self-checking testbench for min_priority_queue_unit: a directed table of queue
// operations, then random operation mixes under idle and stall patterns, checked
// against a predictor. Depends on mpq_pkg, mpq_chan_if and the queue RTL.
`timescale 1ns / 100ps

module min_priority_queue_unit_tb;

    localparam int          CAPACITY       = 64;
    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 12;
    localparam int          LIMIT_CYCLES   = 200000;
    localparam int          RX_HOLD_CYCLES = 200;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          N_DIRECTED     = 25;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;

    typedef struct packed {
        logic signed [31:0] key;
        mpq_pkg::status_t   st;
        logic [6:0]         occ;
    } heap_result_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] key;
        logic               typed;
        logic signed [31:0] exp_key;
        mpq_pkg::status_t   exp_st;
        logic [6:0]         exp_occ;
    } heap_row_t;

    logic clk = 1'b0;
    logic rst_n;

    mpq_in_if  req_ch ();
    mpq_out_if rsp_ch ();

    min_priority_queue_unit #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    logic signed [31:0] held_keys [$];
    heap_result_t       pending_results [$];
    int                 mismatch_count = 0;
    int                 tx_idle_pct    = 0;
    int                 rx_stall_pct   = 0;
    bit                 rx_hold_req    = 1'b0;

    heap_row_t heap_plan [0:N_DIRECTED-1] = '{
        '{mpq_pkg::OP_FIND,    32'sd0,        1'b1, mpq_pkg::EMPTY_MARK, mpq_pkg::ST_EMPTY, 7'd0},
        '{mpq_pkg::OP_EXTRACT, 32'sh12345678, 1'b1, mpq_pkg::EMPTY_MARK, mpq_pkg::ST_EMPTY, 7'd0},
        '{OP_UNUSED,           32'sd0,        1'b1, 32'sd0,              mpq_pkg::ST_OK,    7'd0},
        '{mpq_pkg::OP_INSERT,  32'sh7FFFFFFF, 1'b1, 32'sd0,              mpq_pkg::ST_OK,    7'd1},
        '{mpq_pkg::OP_FIND,    -32'sd1,       1'b1, 32'sh7FFFFFFF,       mpq_pkg::ST_OK,    7'd1},
        '{mpq_pkg::OP_INSERT,  32'sd99999,    1'b1, 32'sd0,              mpq_pkg::ST_OK,    7'd2},
        '{mpq_pkg::OP_INSERT,  32'sd100000,   1'b1, 32'sd0,              mpq_pkg::ST_OK,    7'd3},
        '{mpq_pkg::OP_FIND,    32'sd0,        1'b1, 32'sd99999,          mpq_pkg::ST_OK,    7'd3},
        '{mpq_pkg::OP_INSERT,  32'sh80000000, 1'b1, 32'sd0,              mpq_pkg::ST_OK,    7'd4},
        '{mpq_pkg::OP_FIND,    32'sh55555555, 1'b1, 32'sh80000000,       mpq_pkg::ST_OK,    7'd4},
        '{mpq_pkg::OP_EXTRACT, 32'shAAAAAAAA, 1'b1, 32'sh80000000,       mpq_pkg::ST_OK,    7'd3},
        '{mpq_pkg::OP_EXTRACT, 32'sd0,        1'b1, 32'sd99999,          mpq_pkg::ST_OK,    7'd2},
        '{mpq_pkg::OP_EXTRACT, 32'sd0,        1'b1, 32'sd100000,         mpq_pkg::ST_OK,    7'd1},
        '{mpq_pkg::OP_EXTRACT, 32'sd0,        1'b1, 32'sh7FFFFFFF,       mpq_pkg::ST_OK,    7'd0},
        '{mpq_pkg::OP_EXTRACT, 32'sd0,        1'b1, mpq_pkg::EMPTY_MARK, mpq_pkg::ST_EMPTY, 7'd0},
        '{mpq_pkg::OP_INSERT,  -32'sd1,       1'b0, 32'sd0,              mpq_pkg::ST_OK,    7'd0},
        '{mpq_pkg::OP_INSERT,  32'sd1,        1'b0, 32'sd0,              mpq_pkg::ST_OK,    7'd0},
        '{mpq_pkg::OP_INSERT,  32'sd0,        1'b0, 32'sd0,              mpq_pkg::ST_OK,    7'd0},
        '{mpq_pkg::OP_INSERT,  -32'sd1,       1'b0, 32'sd0,              mpq_pkg::ST_OK,    7'd0},
        '{OP_UNUSED,           32'shFFFFFFFF, 1'b0, 32'sd0,              mpq_pkg::ST_OK,    7'd0},
        '{mpq_pkg::OP_EXTRACT, 32'sd0,        1'b0, 32'sd0,              mpq_pkg::ST_OK,    7'd0},
        '{mpq_pkg::OP_EXTRACT, 32'sd0,        1'b0, 32'sd0,              mpq_pkg::ST_OK,    7'd0},
        '{mpq_pkg::OP_FIND,    32'sd0,        1'b0, 32'sd0,              mpq_pkg::ST_OK,    7'd0},
        '{mpq_pkg::OP_EXTRACT, 32'sd0,        1'b0, 32'sd0,              mpq_pkg::ST_OK,    7'd0},
        '{mpq_pkg::OP_EXTRACT, 32'sd0,        1'b0, 32'sd0,              mpq_pkg::ST_OK,    7'd0}
    };

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic heap_result_t queue_op_result(input logic [1:0] op,
                                                     input logic signed [31:0] key);
        heap_result_t r;
        int           m;
        r.key = 32'sd0;
        r.st  = mpq_pkg::ST_OK;
        case (op)
            mpq_pkg::OP_INSERT:
            begin
                if (held_keys.size() >= CAPACITY)
                begin
                    r.st = mpq_pkg::ST_FULL;
                end
                else
                begin
                    held_keys.insert(held_keys.size(), key);
                end
            end
            mpq_pkg::OP_FIND, mpq_pkg::OP_EXTRACT:
            begin
                if (held_keys.size() == 0)
                begin
                    r.key = mpq_pkg::EMPTY_MARK;
                    r.st  = mpq_pkg::ST_EMPTY;
                end
                else
                begin
                    m = 0;
                    for (int i = 1; i < held_keys.size(); i++)
                    begin
                        if (held_keys[i] < held_keys[m])
                        begin
                            m = i;
                        end
                    end
                    r.key = held_keys[m];
                    if (op == mpq_pkg::OP_EXTRACT)
                    begin
                        held_keys.delete(m);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.occ = 7'(held_keys.size());
        return r;
    endfunction

    function automatic logic signed [31:0] pick_key();
        logic signed [31:0] corner [7] = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd99999,
                                           32'sd99998, 32'sd100000, -32'sd1, 32'sd0};
        int                 sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            return 32'(int'($urandom_range(0, 16)) - 8);
        end
        else if (sel == 3)
        begin
            return corner[$urandom_range(0, 6)];
        end
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_op(input int insert_pct);
        if ($urandom_range(0, 199) == 0)
        begin
            return OP_UNUSED;
        end
        if ($urandom_range(0, 99) < insert_pct)
        begin
            return mpq_pkg::OP_INSERT;
        end
        if ($urandom_range(0, 4) == 0)
        begin
            return mpq_pkg::OP_FIND;
        end
        return mpq_pkg::OP_EXTRACT;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is accepted.
    task automatic send_item(input logic [1:0] op, input logic signed [31:0] key,
                             input logic typed, input heap_result_t typed_res);
        int           gap;
        heap_result_t predicted;
        gap = 0;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.op     <= op;
        req_ch.key_in <= key;
        do
        begin
            @(posedge clk);
        end
        while (req_ch.ready !== 1'b1);
        predicted = queue_op_result(op, key);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
        @(negedge clk);
    endtask

    task automatic run_random(input int count, input int insert_pct);
        for (int i = 0; i < count; i++)
        begin
            send_item(pick_op(insert_pct), pick_key(), 1'b0, '0);
        end
    endtask

    task automatic wait_results_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left     = 0;
        hold_taken    = 1'b0;
        rsp_ch.ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req && !hold_taken)
            begin
                hold_left  = RX_HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (!rx_hold_req)
            begin
                hold_taken = 1'b0;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : rsp_check
        heap_result_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no operation pending: key_out %0d status %0d occupancy %0d",
                       rsp_ch.key_out, rsp_ch.status, rsp_ch.occupancy);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.key_out !== want.key)
                begin
                    $error("key_out: expected %0d, actual %0d", want.key, rsp_ch.key_out);
                    mismatch_count++;
                end
                if (rsp_ch.status !== want.st)
                begin
                    $error("status: expected %0d, actual %0d", want.st, rsp_ch.status);
                    mismatch_count++;
                end
                if (rsp_ch.occupancy !== want.occ)
                begin
                    $error("occupancy: expected %0d, actual %0d", want.occ, rsp_ch.occupancy);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("min_priority_queue_unit verification failed");
        $finish;
    end

    initial
    begin
        heap_result_t typed_res;
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.op     = mpq_pkg::OP_INSERT;
        req_ch.key_in = 32'sd0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            typed_res.key = heap_plan[i].exp_key;
            typed_res.st  = heap_plan[i].exp_st;
            typed_res.occ = heap_plan[i].exp_occ;
            send_item(heap_plan[i].op, heap_plan[i].key, heap_plan[i].typed, typed_res);
        end

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        run_random(85, 95);
        run_random(100, 5);

        tx_idle_pct = 66;
        run_random(50, 60);
        run_random(50, 40);

        // The receiver holds off while items keep coming, so the input stalls.
        tx_idle_pct = 0;
        @(posedge clk);
        rx_hold_req = 1'b1;
        @(negedge clk);
        run_random(12, 70);
        rx_hold_req = 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        rx_stall_pct = 66;
        run_random(70, 85);
        run_random(70, 15);

        tx_idle_pct  = 27;
        rx_stall_pct = 27;
        run_random(40, 55);
        run_random(40, 45);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("min_priority_queue_unit verification clean");
        end
        else
        begin
            $display("min_priority_queue_unit verification failed");
        end
        $finish;
    end

endmodule
